>>> rtl/uvs_pkg.sv
package uvs_pkg;

  localparam int MaxSubdivDefault = 256;
  localparam int SubW  = 9;
  localparam int RadW  = 16;
  localparam int IdxW  = 8;
  localparam int PtW   = 9;
  localparam int QuoW  = 17;
  localparam int NumW  = PtW + 16;
  localparam int DivStages = 5;
  localparam int DivBits   = NumW / DivStages;
  localparam int QtrSteps  = 1024;
  localparam int AddrW = 3;
  localparam int DataW = 32;
  localparam logic [SubW-1:0] SubReset = 9'd16;
  localparam logic [RadW-1:0] RadReset = 16'd256;
  localparam longint unsigned PiQ48 = 64'h3243F6A8885A3;

  typedef enum logic {
    REG_SUBDIVISION = 1'b0,
    REG_RADIUS      = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    SLOT_A0 = 3'd0,
    SLOT_B0 = 3'd1,
    SLOT_C0 = 3'd2,
    SLOT_C1 = 3'd3,
    SLOT_B1 = 3'd4,
    SLOT_D  = 3'd5
  } slot_t;

  typedef logic [14:0] qtr_rom_t [0:QtrSteps];

  typedef struct packed {
    slot_t          slot;
    logic [PtW-1:0] p;
    logic [PtW-1:0] q;
  } job_t;

  typedef struct packed {
    slot_t           slot;
    logic [QuoW-1:0] tp;
    logic [QuoW-1:0] tq;
  } div_t;

  typedef struct packed {
    slot_t              slot;
    logic [QuoW-1:0]    tex_u;
    logic [QuoW-1:0]    tex_v;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } nrm_t;

  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic [QuoW-1:0]    tex_u;
    logic [QuoW-1:0]    tex_v;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    slot_t              vertex_slot;
    logic               last;
  } vtx_t;

  typedef struct packed {
    logic [SubW-1:0] rem;
    logic [NumW-1:0] w;
  } div_state_t;

  // restoring division, DivBits quotient bits per call
  function automatic div_state_t div_steps(input div_state_t st, input logic [SubW-1:0] s);
    div_state_t r;
    logic [SubW:0] t;
    r = st;
    for (int b = 0; b < DivBits; b++) begin
      t = {r.rem, r.w[NumW-1]};
      if (t >= {1'b0, s}) begin
        t = t - {1'b0, s};
        r.w = {r.w[NumW-2:0], 1'b1};
      end else begin
        r.w = {r.w[NumW-2:0], 1'b0};
      end
      r.rem = t[SubW-1:0];
    end
    return r;
  endfunction

  function automatic longint unsigned div_even(input longint unsigned v, input int n);
    longint unsigned r;
    case (n)
      1: r = v / 2;
      2: r = v / 4;
      3: r = v / 6;
      4: r = v / 8;
      5: r = v / 10;
      6: r = v / 12;
      7: r = v / 14;
      default: r = v / 16;
    endcase
    return r;
  endfunction

  function automatic longint unsigned div_odd(input longint unsigned v, input int n);
    longint unsigned r;
    case (n)
      1: r = v / 3;
      2: r = v / 5;
      3: r = v / 7;
      4: r = v / 9;
      5: r = v / 11;
      6: r = v / 13;
      7: r = v / 15;
      default: r = v / 17;
    endcase
    return r;
  endfunction

  // quarter-wave sine, Q1.14, by Taylor series in Q31
  function automatic qtr_rom_t build_qtr_rom();
    qtr_rom_t t;
    longint unsigned x;
    longint unsigned term;
    longint sum;
    for (int k = 0; k <= QtrSteps; k++) begin
      x = (longint'(k) * PiQ48) >> 28;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = div_even((term * x) >> 31, n);
        term = div_odd((term * x) >> 31, n);
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      t[k] = 15'((longint'(sum) * 16384 + (64'd1 << 30)) >> 31);
    end
    return t;
  endfunction

  // quarter table address of a 12-bit angle index
  function automatic logic [10:0] rom_addr(input logic [11:0] idx);
    logic [10:0] r;
    r = {1'b0, idx[9:0]};
    if (idx[10]) r = 11'd1024 - r;
    return r;
  endfunction

  function automatic logic signed [33:0] round14(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = v + 34'sd8192;
    return t >>> 14;
  endfunction

  function automatic logic lat_plus(input slot_t s);
    logic r;
    case (s)
      SLOT_B0, SLOT_B1, SLOT_D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic lon_plus(input slot_t s);
    logic r;
    case (s)
      SLOT_C0, SLOT_C1, SLOT_D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/uvs_if.sv
interface uvs_cell_if;
  logic                     valid;
  logic                     ready;
  logic [uvs_pkg::IdxW-1:0] lat_index;
  logic [uvs_pkg::IdxW-1:0] lon_index;
  modport source (output valid, lat_index, lon_index, input ready);
  modport sink (input valid, lat_index, lon_index, output ready);
endinterface

interface uvs_vtx_if;
  logic                     valid;
  logic                     ready;
  logic signed [16:0]       pos_x;
  logic signed [16:0]       pos_y;
  logic signed [16:0]       pos_z;
  logic [uvs_pkg::QuoW-1:0] tex_u;
  logic [uvs_pkg::QuoW-1:0] tex_v;
  logic signed [15:0]       norm_x;
  logic signed [15:0]       norm_y;
  logic signed [15:0]       norm_z;
  logic [2:0]               vertex_slot;
  logic                     last;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y,
                  norm_z, vertex_slot, last, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y,
                norm_z, vertex_slot, last, output ready);
endinterface

>>> rtl/uvs_seq.sv
module uvs_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [uvs_pkg::SubW-1:0] s_eff,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [uvs_pkg::IdxW-1:0] lat_index,
  input  logic [uvs_pkg::IdxW-1:0] lon_index,
  output logic                     job_valid,
  output uvs_pkg::job_t            job
);
  import uvs_pkg::*;

  logic            busy;
  slot_t           slot;
  logic [IdxW-1:0] ci;
  logic [IdxW-1:0] cj;
  logic [SubW-1:0] smax;
  logic            take;

  assign smax     = s_eff - 9'd1;
  assign in_ready = en && !rst && (!busy || slot == SLOT_D);
  assign take     = in_ready && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      slot      <= SLOT_A0;
      job_valid <= 1'b0;
    end else if (en) begin
      job_valid <= busy;
      if (take) begin
        busy <= 1'b1;
        slot <= SLOT_A0;
      end else if (busy) begin
        slot <= slot_t'(slot + 3'd1);
        if (slot == SLOT_D) busy <= 1'b0;
      end
    end
  end

  // clamp indexes to s_eff-1, the effective subdivision minus one
  always_ff @(posedge clk) begin
    if (en) begin
      job.slot <= slot;
      job.p    <= {1'b0, ci} + {8'd0, lat_plus(slot)};
      job.q    <= {1'b0, cj} + {8'd0, lon_plus(slot)};
      if (take) begin
        ci <= ({1'b0, lat_index} > smax) ? smax[IdxW-1:0] : lat_index;
        cj <= ({1'b0, lon_index} > smax) ? smax[IdxW-1:0] : lon_index;
      end
    end
  end

endmodule

>>> rtl/uvs_div.sv
module uvs_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [uvs_pkg::SubW-1:0] s_eff,
  input  logic                     job_valid,
  input  uvs_pkg::job_t            job,
  output logic                     dv_valid,
  output uvs_pkg::div_t            dv
);
  import uvs_pkg::*;

  logic       vld [DivStages];
  div_state_t stp [DivStages];
  div_state_t stq [DivStages];
  slot_t      sl  [DivStages];
  div_state_t init_p;
  div_state_t init_q;

  assign init_p = '{rem: '0, w: {job.p, 16'd0}};
  assign init_q = '{rem: '0, w: {job.q, 16'd0}};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DivStages; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= job_valid;
      for (int k = 1; k < DivStages; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stp[0] <= div_steps(init_p, s_eff);
      stq[0] <= div_steps(init_q, s_eff);
      sl[0]  <= job.slot;
      for (int k = 1; k < DivStages; k++) begin
        stp[k] <= div_steps(stp[k-1], s_eff);
        stq[k] <= div_steps(stq[k-1], s_eff);
        sl[k]  <= sl[k-1];
      end
    end
  end

  assign dv_valid = vld[DivStages-1];
  assign dv.slot  = sl[DivStages-1];
  assign dv.tp    = stp[DivStages-1].w[QuoW-1:0];
  assign dv.tq    = stq[DivStages-1].w[QuoW-1:0];

endmodule

>>> rtl/uvs_trig.sv
module uvs_trig (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          dv_valid,
  input  uvs_pkg::div_t dv,
  output logic          nv_valid,
  output uvs_pkg::nrm_t nv
);
  import uvs_pkg::*;

  localparam qtr_rom_t LatRom = build_qtr_rom();
  localparam qtr_rom_t LonRom = build_qtr_rom();

  logic [15:0] lat16;
  logic [15:0] lon16;
  logic [16:0] lat_r;
  logic [16:0] lon_r;
  logic [11:0] li;
  logic [11:0] lo;
  logic [11:0] li_c;
  logic [11:0] lo_c;

  // stage a: table read
  logic        a_valid;
  slot_t       a_slot;
  logic [QuoW-1:0] a_tu;
  logic [QuoW-1:0] a_tv;
  logic [14:0] a_sl;
  logic [14:0] a_cl;
  logic [14:0] a_so;
  logic [14:0] a_co;
  logic        a_nsl;
  logic        a_ncl;
  logic        a_nso;
  logic        a_nco;
  // stage b: products
  logic        b_valid;
  slot_t       b_slot;
  logic [QuoW-1:0] b_tu;
  logic [QuoW-1:0] b_tv;
  logic signed [15:0] b_ny;
  logic signed [31:0] b_px;
  logic signed [31:0] b_pz;

  logic signed [15:0] sl_s;
  logic signed [15:0] cl_s;
  logic signed [15:0] so_s;
  logic signed [15:0] co_s;
  logic signed [33:0] rx;
  logic signed [33:0] rz;

  assign lat16 = dv.tp[QuoW-1:1] + 16'd49152;
  assign lon16 = dv.tq[15:0];
  assign lat_r = {1'b0, lat16} + 17'd8;
  assign lon_r = {1'b0, lon16} + 17'd8;
  assign li    = lat_r[15:4];
  assign lo    = lon_r[15:4];
  assign li_c  = li + 12'd1024;
  assign lo_c  = lo + 12'd1024;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      nv_valid <= 1'b0;
    end else if (en) begin
      a_valid  <= dv_valid;
      b_valid  <= a_valid;
      nv_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sl  <= LatRom[rom_addr(li)];
      a_cl  <= LatRom[rom_addr(li_c)];
      a_so  <= LonRom[rom_addr(lo)];
      a_co  <= LonRom[rom_addr(lo_c)];
      a_nsl <= li[11];
      a_ncl <= li_c[11];
      a_nso <= lo[11];
      a_nco <= lo_c[11];
      a_slot <= dv.slot;
      a_tu  <= dv.tq;
      a_tv  <= 17'd65536 - dv.tp;
    end
  end

  assign sl_s = a_nsl ? -$signed({1'b0, a_sl}) : $signed({1'b0, a_sl});
  assign cl_s = a_ncl ? -$signed({1'b0, a_cl}) : $signed({1'b0, a_cl});
  assign so_s = a_nso ? -$signed({1'b0, a_so}) : $signed({1'b0, a_so});
  assign co_s = a_nco ? -$signed({1'b0, a_co}) : $signed({1'b0, a_co});

  always_ff @(posedge clk) begin
    if (en) begin
      b_slot <= a_slot;
      b_tu   <= a_tu;
      b_tv   <= a_tv;
      b_ny   <= sl_s;
      b_px   <= cl_s * co_s;
      b_pz   <= cl_s * so_s;
    end
  end

  assign rx = round14(34'(b_px));
  assign rz = round14(34'(b_pz));

  always_ff @(posedge clk) begin
    if (en) begin
      nv.slot  <= b_slot;
      nv.tex_u <= b_tu;
      nv.tex_v <= b_tv;
      nv.nx    <= rx[15:0];
      nv.ny    <= b_ny;
      nv.nz    <= rz[15:0];
    end
  end

endmodule

>>> rtl/uvs_scale.sv
module uvs_scale (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [uvs_pkg::RadW-1:0] radius,
  input  logic                     nv_valid,
  input  uvs_pkg::nrm_t            nv,
  output logic                     vx_valid,
  output uvs_pkg::vtx_t            vx
);
  import uvs_pkg::*;

  logic               d_valid;
  nrm_t               d_n;
  logic signed [32:0] d_px;
  logic signed [32:0] d_py;
  logic signed [32:0] d_pz;
  logic signed [16:0] r_s;
  logic signed [33:0] rx;
  logic signed [33:0] ry;
  logic signed [33:0] rz;

  assign r_s = $signed({1'b0, radius});

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid  <= 1'b0;
      vx_valid <= 1'b0;
    end else if (en) begin
      d_valid  <= nv_valid;
      vx_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_n  <= nv;
      d_px <= r_s * nv.nx;
      d_py <= r_s * nv.ny;
      d_pz <= r_s * nv.nz;
    end
  end

  assign rx = round14(34'(d_px));
  assign ry = round14(34'(d_py));
  assign rz = round14(34'(d_pz));

  always_ff @(posedge clk) begin
    if (en) begin
      vx.pos_x       <= rx[16:0];
      vx.pos_y       <= ry[16:0];
      vx.pos_z       <= rz[16:0];
      vx.tex_u       <= d_n.tex_u;
      vx.tex_v       <= d_n.tex_v;
      vx.norm_x      <= d_n.nx;
      vx.norm_y      <= d_n.ny;
      vx.norm_z      <= d_n.nz;
      vx.vertex_slot <= d_n.slot;
      vx.last        <= (d_n.slot == SLOT_D);
    end
  end

endmodule

>>> rtl/uv_sphere_cell_vertex_generator.sv
// channel  | dir | payload                                         | handshake
// tile     | in  | lat_index, lon_index                            | valid/ready
// vtx      | out | pos_x/y/z, tex_u/v, norm_x/y/z, vertex_slot, last | valid/ready
// apb      | in  | subdivision @0x0, radius @0x4                   | psel/penable
//
// the sequencer issues one vertex per cycle, unless the output queue is full,
// into an 11-stage pipeline (job register, 5 divider, 3 trig, 2 scale stages);
// each cell gives six vertices, and the next cell is taken as the last one issues
// rst is synchronous, clears all valid bits and restores register defaults
// a 2-entry output queue absorbs vtx stalls; the pipeline freezes as a
// whole only when the queue is full, so nothing is dropped or repeated
module uv_sphere_cell_vertex_generator #(
  parameter int MAX_SUBDIVISION = uvs_pkg::MaxSubdivDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  uvs_cell_if.sink                  tile,
  uvs_vtx_if.source                 vtx,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [uvs_pkg::AddrW-1:0] paddr,
  input  logic [uvs_pkg::DataW-1:0] pwdata,
  output logic [uvs_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import uvs_pkg::*;

  logic [SubW-1:0] subdivision;
  logic [RadW-1:0] radius;
  logic [SubW-1:0] s_eff;
  reg_idx_t        reg_sel;
  logic            wr_en;

  // pipeline hookup
  logic  en;
  logic  job_valid;
  job_t  job;
  logic  dv_valid;
  div_t  dv;
  logic  nv_valid;
  nrm_t  nv;
  logic  vx_valid;
  vtx_t  vx;

  // output queue
  vtx_t       q_mem [2];
  logic       q_rd;
  logic       q_wr;
  logic [1:0] q_cnt;
  logic       push;
  logic       pop;

  // config registers, written on the apb access phase
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      subdivision <= SubReset;
      radius      <= RadReset;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SUBDIVISION: subdivision <= pwdata[SubW-1:0];
        REG_RADIUS:      radius      <= pwdata[RadW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SUBDIVISION: prdata = {{(DataW-SubW){1'b0}}, subdivision};
      REG_RADIUS:      prdata = {{(DataW-RadW){1'b0}}, radius};
      default:         prdata = '0;
    endcase
  end

  // zero acts as one, large values saturate at the maximum
  always_comb begin
    if (subdivision == '0) s_eff = 9'd1;
    else if ({2'b00, subdivision} > 11'(MAX_SUBDIVISION)) s_eff = 9'(MAX_SUBDIVISION);
    else s_eff = subdivision;
  end

  // whole pipeline advances unless the output queue is full
  assign en = (q_cnt != 2'd2);

  uvs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .s_eff     (s_eff),
    .in_valid  (tile.valid),
    .in_ready  (tile.ready),
    .lat_index (tile.lat_index),
    .lon_index (tile.lon_index),
    .job_valid (job_valid),
    .job       (job)
  );

  uvs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .s_eff     (s_eff),
    .job_valid (job_valid),
    .job       (job),
    .dv_valid  (dv_valid),
    .dv        (dv)
  );

  uvs_trig u_trig (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .dv_valid (dv_valid),
    .dv       (dv),
    .nv_valid (nv_valid),
    .nv       (nv)
  );

  uvs_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .radius   (radius),
    .nv_valid (nv_valid),
    .nv       (nv),
    .vx_valid (vx_valid),
    .vx       (vx)
  );

  // a valid last stage moves into the queue whenever the pipeline advances
  assign push = en && vx_valid;
  assign pop  = vtx.valid && vtx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_rd  <= 1'b0;
      q_wr  <= 1'b0;
      q_cnt <= 2'd0;
    end else begin
      if (push) q_wr <= ~q_wr;
      if (pop)  q_rd <= ~q_rd;
      case ({push, pop})
        2'b10:   q_cnt <= q_cnt + 2'd1;
        2'b01:   q_cnt <= q_cnt - 2'd1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[q_wr] <= vx;
  end

  assign vtx.valid       = (q_cnt != 2'd0);
  assign vtx.pos_x       = q_mem[q_rd].pos_x;
  assign vtx.pos_y       = q_mem[q_rd].pos_y;
  assign vtx.pos_z       = q_mem[q_rd].pos_z;
  assign vtx.tex_u       = q_mem[q_rd].tex_u;
  assign vtx.tex_v       = q_mem[q_rd].tex_v;
  assign vtx.norm_x      = q_mem[q_rd].norm_x;
  assign vtx.norm_y      = q_mem[q_rd].norm_y;
  assign vtx.norm_z      = q_mem[q_rd].norm_z;
  assign vtx.vertex_slot = q_mem[q_rd].vertex_slot;
  assign vtx.last        = q_mem[q_rd].last;

endmodule

>>> rtl/uvs_checker.sv
module uvs_checker (
  input logic       clk,
  input logic       rst,
  input logic       cell_valid,
  input logic       cell_ready,
  input logic       vtx_valid,
  input logic       vtx_ready,
  input logic [2:0] vertex_slot,
  input logic       last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    vtx_valid && !vtx_ready |=> vtx_valid)
    else $error("vtx item dropped while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    vtx_valid |-> (last == (vertex_slot == 3'd5)))
    else $error("last does not mark the sixth vertex");

  a_seq: assert property (@(posedge clk) disable iff (rst)
    vtx_valid && vtx_ready && vertex_slot != 3'd5 |=>
      vtx_valid && vertex_slot == $past(vertex_slot) + 3'd1)
    else $error("vertex slots not contiguous");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    cell_valid && cell_ready |=> !cell_ready)
    else $error("cell taken while previous cell still issuing");

  a_rst: assert property (@(posedge clk)
    rst |=> !vtx_valid)
    else $error("vtx valid right after reset");

endmodule

bind uv_sphere_cell_vertex_generator uvs_checker u_uvs_checker (
  .clk         (clk),
  .rst         (rst),
  .cell_valid  (tile.valid),
  .cell_ready  (tile.ready),
  .vtx_valid   (vtx.valid),
  .vtx_ready   (vtx.ready),
  .vertex_slot (vtx.vertex_slot),
  .last        (vtx.last)
);
